>>> rtl/b64d_pkg.sv
`default_nettype none

package b64d_pkg;

    localparam int unsigned COUNT_BITS_DEF = 16;
    localparam int unsigned QUEUE_DEPTH    = 4;
    localparam int unsigned QUEUE_AW       = $clog2(QUEUE_DEPTH);

    localparam logic [7:0] PAD_CHAR = 8'h3D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_SLASH = 8'h2F;

    // one decoded quad (or end marker) handed from front to back
    typedef struct packed {
        logic [2:0][7:0] bytes;   // bytes[0] goes out first
        logic [1:0]      nb;      // number of data bytes, 0..3
        logic            eos;     // last item of the string
        logic            err;     // sticky error as it stands after this item
    } t_job;

    // {invalid, sextet}; '=' and invalid characters both decode to zero bits
    function automatic logic [6:0] sextet_of(input logic [7:0] c);
        logic [6:0] r;
        r = 7'h40;
        case (c) inside
            [8'h41:8'h5A]: r = {1'b0, 6'(c - 8'h41)};
            [8'h61:8'h7A]: r = {1'b0, 6'(c - 8'h61 + 8'd26)};
            [8'h30:8'h39]: r = {1'b0, 6'(c - 8'h30 + 8'd52)};
            CH_PLUS:       r = {1'b0, 6'd62};
            CH_SLASH:      r = {1'b0, 6'd63};
            PAD_CHAR:      r = 7'h00;
            default:       r = 7'h40;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

>>> rtl/b64d_front.sv
`default_nettype none

module b64d_front (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_accept,
    input  wire  [7:0]       i_char,
    input  wire              i_eos,
    output logic             o_push,
    output b64d_pkg::t_job   o_job
);
    import b64d_pkg::*;

    logic [17:0] r_buf, n_buf;
    logic [1:0]  r_pos, n_pos;
    logic        r_third, n_third;
    logic        r_padded, n_padded;
    logic        r_err, n_err;

    logic [6:0]  dec;
    logic        is_pad;
    logic [23:0] word;
    t_job        job;

    always_comb begin
        dec      = sextet_of(i_char);
        is_pad   = (i_char == PAD_CHAR);
        word     = {r_buf, dec[5:0]};
        n_buf    = r_buf;
        n_pos    = r_pos;
        n_third  = r_third;
        n_padded = r_padded;
        n_err    = r_err | dec[6];
        job      = '0;

        if (r_pos != 2'd3) begin
            if (is_pad && (r_pos != 2'd2)) begin
                n_err = 1'b1;
            end
            if (r_pos == 2'd2) begin
                n_third = is_pad;
            end
            n_buf = {r_buf[11:0], dec[5:0]};
            n_pos = r_pos + 2'd1;
        end else begin
            if ((r_third && !is_pad) || r_padded) begin
                n_err = 1'b1;
            end
            job.bytes[0] = word[23:16];
            if (!r_third) begin
                job.bytes[1] = word[15:8];
                job.bytes[2] = word[7:0];
            end else begin
                job.bytes[1] = word[7:0];
            end
            // bytes past nb are cleared to zero and are never shown
            if (is_pad) begin
                job.bytes[2] = '0;
                if (r_third) job.bytes[1] = '0;
            end
            job.nb   = 2'd1 + {1'b0, !r_third} + {1'b0, !is_pad};
            n_padded = r_padded | r_third | is_pad;
            n_buf    = '0;
            n_pos    = '0;
            n_third  = 1'b0;
        end
        job.eos = i_eos;
        job.err = n_err;
    end

    assign o_push = i_accept && ((job.nb != 2'd0) || i_eos);
    assign o_job  = job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buf    <= '0;
            r_pos    <= '0;
            r_third  <= 1'b0;
            r_padded <= 1'b0;
            r_err    <= 1'b0;
        end else if (i_accept) begin
            if (i_eos) begin
                r_buf    <= '0;
                r_pos    <= '0;
                r_third  <= 1'b0;
                r_padded <= 1'b0;
                r_err    <= 1'b0;
            end else begin
                r_buf    <= n_buf;
                r_pos    <= n_pos;
                r_third  <= n_third;
                r_padded <= n_padded;
                r_err    <= n_err;
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/b64d_queue.sv
`default_nettype none

module b64d_queue (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_push,
    input  wire b64d_pkg::t_job i_job,
    input  wire              i_pop,
    output b64d_pkg::t_job   o_head,
    output logic             o_empty,
    output logic             o_full
);
    import b64d_pkg::*;

    t_job                r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wp, r_rp;
    logic [QUEUE_AW:0]   r_cnt;

    assign o_head  = r_mem[r_rp];
    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == (QUEUE_AW+1)'(QUEUE_DEPTH));

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (i_pop)  r_rp <= r_rp + 1'b1;
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

`default_nettype wire

>>> rtl/b64d_back.sv
`default_nettype none

module b64d_back #(
    parameter int unsigned COUNT_BITS = b64d_pkg::COUNT_BITS_DEF
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire b64d_pkg::t_job i_head,
    input  wire              i_empty,
    output logic             o_pop,
    output logic             o_valid,
    input  wire              i_ready,
    output logic [7:0]       o_byte,
    output logic             o_byte_valid,
    output logic             o_last,
    output logic             o_bad,
    output logic [15:0]      o_count
);
    import b64d_pkg::*;

    logic [1:0]            r_idx;
    logic [COUNT_BITS-1:0] r_cnt, n_cnt;
    logic                  r_valid;
    logic [7:0]            r_byte;
    logic                  r_bvalid, r_last, r_bad;
    logic [15:0]           r_shown, n_shown;

    logic       advance, has_data, at_end;
    logic [1:0] n_res_m1;

    always_comb begin
        has_data = (i_head.nb != 2'd0);
        n_res_m1 = has_data ? (i_head.nb - 2'd1) : 2'd0;
        at_end   = (r_idx == n_res_m1);
        advance  = !i_empty && (!r_valid || i_ready);
        n_cnt    = r_cnt;
        if (has_data && (r_cnt != '1)) begin
            n_cnt = r_cnt + 1'b1;
        end
        if ((COUNT_BITS > 16) && ((n_cnt >> 16) != '0)) begin
            n_shown = 16'hFFFF;
        end else begin
            n_shown = 16'(n_cnt);
        end
    end

    assign o_pop = advance && at_end;

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_byte   <= has_data ? i_head.bytes[r_idx] : 8'h00;
            r_bvalid <= has_data;
            r_last   <= i_head.eos && at_end;
            r_bad    <= i_head.err;
            r_shown  <= n_shown;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
            r_cnt   <= '0;
        end else begin
            if (advance) begin
                r_valid <= 1'b1;
                r_idx   <= at_end ? 2'd0 : r_idx + 2'd1;
                r_cnt   <= (i_head.eos && at_end) ? '0 : n_cnt;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    assign o_valid      = r_valid;
    assign o_byte       = r_byte;
    assign o_byte_valid = r_bvalid;
    assign o_last       = r_last;
    assign o_bad        = r_bad;
    assign o_count      = r_shown;

endmodule

`default_nettype wire

>>> rtl/base64_stream_decoder.sv
`default_nettype none

// channel   dir  tdata                                       tuser       tlast
// s (in)    in   [7:0] char_in                               -           end_of_string
// m (out)   out  [7:0] byte_out, [8] bad_input,              byte_valid  last_result
//                [24:9] byte_count, [31:25] zero
//
// one character is taken every cycle while the queue between front and back has room
// a full quad gives up to three beats, one per ready cycle from the back's output register
// characters flow with no gaps since four characters never yield more than three beats
// a quad's first beat is written into the queue, then into the back end's output register
// synchronous active-low reset empties the queue and clears all string state
// a stalled output fills the four-entry queue, then tready falls

module base64_stream_decoder #(
    parameter int unsigned COUNT_BITS = b64d_pkg::COUNT_BITS_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // input stream: one encoded character per beat
    input  wire         i_s_tvalid,
    output logic        o_s_tready,
    input  wire  [7:0]  i_s_tdata,    // [7:0] char_in
    input  wire         i_s_tlast,    // end_of_string
    // output stream: decoded bytes and end-of-string status
    output logic        o_m_tvalid,
    input  wire         i_m_tready,
    output logic [31:0] o_m_tdata,    // [7:0] byte_out, [8] bad_input, [24:9] byte_count
    output logic        o_m_tuser,    // byte_valid
    output logic        o_m_tlast     // last_result
);
    import b64d_pkg::*;

    logic  accept;
    logic  push, pop, q_empty, q_full;
    t_job  job, head;

    logic [7:0]  out_byte;
    logic        out_bad;
    logic [15:0] out_count;

    // front takes a beat whenever the queue can hold its result
    assign o_s_tready = !q_full;
    assign accept     = i_s_tvalid && o_s_tready;

    // quad assembly, padding checks and sticky error
    b64d_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_char   (i_s_tdata),
        .i_eos    (i_s_tlast),
        .o_push   (push),
        .o_job    (job)
    );

    // decouples character intake from byte output
    b64d_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (job),
        .i_pop   (pop),
        .o_head  (head),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    // serializes each queued quad into beats and keeps the byte count
    b64d_back #(
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (head),
        .i_empty      (q_empty),
        .o_pop        (pop),
        .o_valid      (o_m_tvalid),
        .i_ready      (i_m_tready),
        .o_byte       (out_byte),
        .o_byte_valid (o_m_tuser),
        .o_last       (o_m_tlast),
        .o_bad        (out_bad),
        .o_count      (out_count)
    );

    assign o_m_tdata = {7'b0, out_count, out_bad, out_byte};

endmodule

`default_nettype wire
